// ===== hdl/css_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// css_pkg: shared types and constants of the cursor sequence store
// Command and status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package css_pkg;

	// Default sizes of the store.
	localparam int CAPACITY_DEF   = 64;
	localparam int DATA_WIDTH_DEF = 32;

	// Fixed widths of the command and result fields.
	localparam int CMD_W   = 3;
	localparam int VALUE_W = 32;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 7;
	localparam int POS_W   = 6;

	// Command codes.
	typedef enum logic [CMD_W-1:0] {
		CMD_START   = 3'd0,
		CMD_END     = 3'd1,
		CMD_ADVANCE = 3'd2,
		CMD_INSERT  = 3'd3,
		CMD_ATTACH  = 3'd4,
		CMD_REMOVE  = 3'd5,
		CMD_QUERY   = 3'd6
	} cmd_t;

	// Result status codes.
	typedef enum logic [STAT_W-1:0] {
		STAT_OK   = 2'd0,
		STAT_NONE = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SHIFT,
		ST_PLACE,
		ST_LOOKUP,
		ST_READ
	} state_t;

endpackage

// ===== hdl/cursor_sequence_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_sequence_store: ordered value store with a current-item cursor
// A single memory holds the values in order; a small sequencer opens or
// closes a gap by moving entries one per cycle through the memory port.
// ----------------------------------------------------------------------------
// Usage:
// A command transaction is taken at a rising edge with start high and busy
// low; cmd selects the operation and item_value gives the value for insert
// and attach. busy stays high until the result is presented. Each result
// appears on status, item_count, has_current, current_value and
// current_position for exactly one cycle while done is high; the receiver
// cannot stall it. busy falls in the same cycle as done, so the next command
// may be taken at the edge that ends the result cycle.
// Each command passes through the sequencer states in order: the decode
// (EXEC); the entry move (SHIFT) for a remove, insert or attach that is not
// rejected; the value write (PLACE) for such an insert or attach; then the
// lookup (LOOKUP) and the read (READ), after which done is raised.
// The memory port moves one entry per cycle, so the longest command is an
// insert at the front of a store that holds CAPACITY - 1 values.
// Reset empties the store and clears the cursor; the memory contents are not
// cleared, as only entries below the count are ever used in a result.
// ----------------------------------------------------------------------------
module cursor_sequence_store
	import css_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [CMD_W-1:0]   cmd,
	input  logic [VALUE_W-1:0] item_value,
	output logic               done,
	output logic [STAT_W-1:0]  status,
	output logic [COUNT_W-1:0] item_count,
	output logic               has_current,
	output logic [VALUE_W-1:0] current_value,
	output logic [POS_W-1:0]   current_position
);

	localparam int IW     = $clog2(CAPACITY);
	localparam int CW     = $clog2(CAPACITY + 1);
	localparam int VW     = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
	localparam int CNT_OW = (CW < COUNT_W) ? CW : COUNT_W;
	localparam int POS_OW = (IW < POS_W) ? IW : POS_W;

	// Sequencer and store state.
	state_t                state_q, state_nxt;
	cmd_t                  cmd_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [CW-1:0]         count_q;
	logic [IW-1:0]         cur_q;
	logic                  pres_q;
	logic [IW-1:0]         ptr_q;
	logic [CW-1:0]         rem_q;
	logic                  up_q;
	logic [IW-1:0]         pos_q;
	logic                  place_q;

	// Write stage of the entry move.
	logic                  wv_s1;
	logic [IW-1:0]         wa_s1;

	// Memory and its ports.
	logic [DATA_WIDTH-1:0] mem [CAPACITY];
	logic [DATA_WIDTH-1:0] rdata_q;
	logic                  rd_en;
	logic [IW-1:0]         rd_addr;
	logic                  wr_en;
	logic [IW-1:0]         wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;

	// Result registers.
	logic                  done_q;
	status_t               out_status_q;
	logic [COUNT_W-1:0]    out_count_q;
	logic                  out_has_q;
	logic [VALUE_W-1:0]    out_value_q;
	logic [POS_W-1:0]      out_pos_q;

	// Decode results.
	status_t               dec_status;
	logic [CW-1:0]         dec_count;
	logic [IW-1:0]         dec_cur;
	logic                  dec_pres;
	logic [IW-1:0]         dec_ptr;
	logic [CW-1:0]         dec_rem;
	logic                  dec_up;
	logic [IW-1:0]         dec_pos;
	logic                  dec_place;
	logic                  dec_shift;

	logic                  accept;
	logic                  full;

	assign accept = start && !busy;
	assign full   = (count_q >= CW'(CAPACITY));

	// Command decode: status, new cursor and count, and the range of entries to move.
	always_comb begin
		dec_status = STAT_OK;
		dec_count  = count_q;
		dec_cur    = cur_q;
		dec_pres   = pres_q;
		dec_ptr    = ptr_q;
		dec_rem    = '0;
		dec_up     = 1'b0;
		dec_pos    = '0;
		dec_place  = 1'b0;
		dec_shift  = 1'b0;
		unique case (cmd_q)
			CMD_START, CMD_END: begin
				if (count_q == '0) begin
					dec_pres = 1'b0;
					dec_cur  = '0;
				end else begin
					dec_pres = 1'b1;
					dec_cur  = (cmd_q == CMD_START) ? '0 : IW'(count_q - CW'(1));
				end
			end
			CMD_ADVANCE: begin
				if (!pres_q) begin
					dec_status = STAT_NONE;
				end else if ((CW'(cur_q) + CW'(1)) >= count_q) begin
					dec_pres = 1'b0;
					dec_cur  = '0;
				end else begin
					dec_cur = cur_q + IW'(1);
				end
			end
			CMD_INSERT, CMD_ATTACH: begin
				if (full) begin
					dec_status = STAT_FULL;
				end else begin
					if (cmd_q == CMD_INSERT) begin
						dec_pos = pres_q ? cur_q : '0;
					end else begin
						dec_pos = pres_q ? (cur_q + IW'(1)) : IW'(count_q);
					end
					dec_ptr   = IW'(count_q - CW'(1));
					dec_rem   = count_q - CW'(dec_pos);
					dec_up    = 1'b1;
					dec_place = 1'b1;
					dec_shift = 1'b1;
					dec_cur   = dec_pos;
					dec_pres  = 1'b1;
					dec_count = count_q + CW'(1);
				end
			end
			CMD_REMOVE: begin
				if (!pres_q || (CW'(cur_q) >= count_q)) begin
					dec_status = STAT_NONE;
				end else begin
					dec_ptr   = IW'(CW'(cur_q) + CW'(1));
					dec_rem   = count_q - CW'(1) - CW'(cur_q);
					dec_shift = 1'b1;
					dec_count = count_q - CW'(1);
					if (CW'(cur_q) >= (count_q - CW'(1))) begin
						dec_pres = 1'b0;
						dec_cur  = '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept) state_nxt = ST_EXEC;
			ST_EXEC:   state_nxt = dec_shift ? ST_SHIFT : ST_LOOKUP;
			ST_SHIFT: begin
				if (rem_q == '0) begin
					state_nxt = place_q ? ST_PLACE : ST_LOOKUP;
				end
			end
			ST_PLACE:  state_nxt = ST_LOOKUP;
			ST_LOOKUP: state_nxt = ST_READ;
			ST_READ:   state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// Memory port control per state.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cur_q;
		wr_en   = 1'b0;
		wr_addr = wa_s1;
		wr_data = rdata_q;
		unique case (state_q)
			ST_SHIFT: begin
				rd_en   = (rem_q != '0);
				rd_addr = ptr_q;
				wr_en   = wv_s1;
			end
			ST_PLACE: begin
				wr_en   = 1'b1;
				wr_addr = pos_q;
				wr_data = val_q;
			end
			ST_LOOKUP: begin
				rd_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	// Value memory with registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Sequencer, cursor and count registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			cur_q   <= '0;
			pres_q  <= 1'b0;
			rem_q   <= '0;
			wv_s1   <= 1'b0;
			place_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= (state_q == ST_READ);
			wv_s1   <= (state_q == ST_SHIFT) && (rem_q != '0);
			if (state_q == ST_EXEC) begin
				count_q <= dec_count;
				cur_q   <= dec_cur;
				pres_q  <= dec_pres;
				rem_q   <= dec_rem;
				place_q <= dec_place;
			end else if ((state_q == ST_SHIFT) && (rem_q != '0)) begin
				rem_q <= rem_q - CW'(1);
			end
		end
	end

	// Command capture and move pointer; payload needs no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_t'(cmd);
			val_q <= DATA_WIDTH'(item_value[VW-1:0]);
		end
		if (state_q == ST_EXEC) begin
			ptr_q <= dec_ptr;
			up_q  <= dec_up;
			pos_q <= dec_pos;
		end else if ((state_q == ST_SHIFT) && (rem_q != '0)) begin
			ptr_q <= up_q ? (ptr_q - IW'(1)) : (ptr_q + IW'(1));
		end
		wa_s1 <= up_q ? (ptr_q + IW'(1)) : (ptr_q - IW'(1));
	end

	// Result registers: the status is loaded at decode, the rest as the transaction completes.
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			out_status_q <= dec_status;
		end
		if (state_q == ST_READ) begin
			out_count_q <= COUNT_W'(count_q[CNT_OW-1:0]);
			out_has_q   <= pres_q;
			out_value_q <= pres_q ? VALUE_W'(rdata_q[VW-1:0]) : '0;
			out_pos_q   <= pres_q ? POS_W'(cur_q[POS_OW-1:0]) : '0;
		end
	end

	assign done             = done_q;
	assign status           = out_status_q;
	assign item_count       = out_count_q;
	assign has_current      = out_has_q;
	assign current_value    = out_value_q;
	assign current_position = out_pos_q;

	// Checks on the sequencer and store bookkeeping.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("item count above capacity");

	a_cursor_inside: assert property (@(posedge clk) disable iff (!arst_n)
		pres_q |-> (CW'(cur_q) < count_q))
		else $error("cursor points past the last item");

	a_done_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == ST_READ))
		else $error("result strobe without a completed lookup");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EXEC))
		else $error("accepted transaction not decoded");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for more than one cycle");

endmodule
